FILE: rtl/cube_face_lut_address_unit_assert.svh
// Assertion macros shared by the cube face address unit.
`ifndef CUBE_FACE_LUT_ADDRESS_UNIT_ASSERT_SVH
`define CUBE_FACE_LUT_ADDRESS_UNIT_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define CFLA_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define CFLA_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/cfla_pkg.sv
// Types and constants of the cube face address unit.
`default_nettype none

package cfla_pkg;

  localparam int DIR_W      = 16;
  localparam int FACE_W     = 3;
  localparam int GRID_W     = 8;
  localparam int OFFS_W     = 21;
  localparam int SIZE_W     = 9;
  localparam int HALF_W     = 7;
  localparam int WARP_W     = 24;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 24;

  // Pipeline depth: input register through output register.
  localparam int NSTG = 9;

  localparam logic [SIZE_W-1:0] MIN_LUT_SIZE = 9'd3;
  localparam logic [SIZE_W-1:0] MAX_LUT_SIZE = 9'd256;

  localparam logic signed [DIR_W-1:0] FACE_LIMIT     = 16'sd8192;
  localparam logic signed [DIR_W-1:0] NEG_FACE_LIMIT = -16'sd8192;

  localparam logic [49:0] Q32_ONE  = 50'h1_0000_0000;
  localparam logic [57:0] Q31_HALF = 58'h8000_0000;

  typedef enum logic [FACE_W-1:0] {
    FACE_POS_Z = 3'd0,
    FACE_NEG_Z = 3'd1,
    FACE_POS_X = 3'd2,
    FACE_NEG_X = 3'd3,
    FACE_POS_Y = 3'd4,
    FACE_NEG_Y = 3'd5
  } face_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_LUT_SIZE    = 2'd0,
    CFG_WARP_BETA   = 2'd1,
    CFG_WARP_GAIN   = 2'd2,
    CFG_WARP_OFFSET = 2'd3
  } cfg_idx_t;

  // Warp settings as seen by one coordinate lane.
  typedef struct packed {
    logic [WARP_W-1:0] beta;
    logic [WARP_W-1:0] gain;
    logic [WARP_W-1:0] offset;
    logic [GRID_W-1:0] size_m1;
    logic [HALF_W-1:0] half;
  } warp_cfg_t;

  // Load enables of the lane's pipeline registers.
  typedef struct packed {
    logic st1;
    logic st2;
    logic st3;
    logic st4;
    logic st5;
    logic st6;
  } lane_load_t;

endpackage

`default_nettype wire

FILE: rtl/cube_face_lut_address_unit.sv
// Top level of the cube face lookup table address unit.
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+---------------------------------------
//  in      | input     | in_valid/in_stall  | in_dir_x, in_dir_y, in_dir_z
//  out     | output    | out_valid/out_stall| out_face, out_grid_u, out_grid_v,
//          |           |                    | out_lut_offset
//  cfg     | input     | cfg_wr_en          | cfg_index, cfg_data
//
// Nine register stages from input to output; one item can enter every cycle while the
// output is not stalled. The depth is set by the two multipliers and the scaling
// product in each coordinate lane plus the offset multiply-add.
// Each stage loads when it is empty or its item moves on, so bubbles close up and
// the input keeps taking items on a stalled output until all nine stages are full.
// Reset (rst_n low, synchronous) empties the pipeline and restores the configuration registers.
`default_nettype none

`include "cube_face_lut_address_unit_assert.svh"

module cube_face_lut_address_unit (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic signed [cfla_pkg::DIR_W-1:0]     in_dir_x,
  input  logic signed [cfla_pkg::DIR_W-1:0]     in_dir_y,
  input  logic signed [cfla_pkg::DIR_W-1:0]     in_dir_z,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic [cfla_pkg::FACE_W-1:0]           out_face,
  output logic [cfla_pkg::GRID_W-1:0]           out_grid_u,
  output logic [cfla_pkg::GRID_W-1:0]           out_grid_v,
  output logic [cfla_pkg::OFFS_W-1:0]           out_lut_offset,
  input  logic                                  cfg_wr_en,
  input  logic [cfla_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [cfla_pkg::CFG_DATA_W-1:0]       cfg_data
);
  import cfla_pkg::*;

  // Configuration registers and values derived from them.
  logic [SIZE_W-1:0] lut_size_r;
  logic [WARP_W-1:0] warp_beta_r;
  logic [WARP_W-1:0] warp_gain_r;
  logic [WARP_W-1:0] warp_offset_r;
  logic [SIZE_W-1:0] size_nxt;
  logic [SIZE_W-1:0] size_r;
  logic [GRID_W-1:0] size_m1_r;
  logic [HALF_W-1:0] half_r;
  logic [SIZE_W-1:0] size_m1_full;
  warp_cfg_t         lane_cfg;

  // Pipeline control.
  logic [NSTG-1:0]   vld_r;
  logic [NSTG:0]     ld;
  lane_load_t        lane_ld;

  // Stage 0: input register.
  logic signed [DIR_W-1:0] x0_r;
  logic signed [DIR_W-1:0] y0_r;
  logic signed [DIR_W-1:0] z0_r;

  face_t                   face_sel;
  logic signed [DIR_W-1:0] fu_sel;
  logic signed [DIR_W-1:0] fv_sel;

  face_t             face_r [1:7];
  logic [GRID_W-1:0] u_idx;
  logic [GRID_W-1:0] v_idx;

  logic [GRID_W-1:0] u7_r;
  logic [GRID_W-1:0] v7_r;
  logic [16:0]       m_nxt;
  logic [16:0]       m7_r;

  logic [16:0]       cell_sum;
  logic [21:0]       off_nxt;
  logic [OFFS_W-1:0] off8_r;
  logic [GRID_W-1:0] u8_r;
  logic [GRID_W-1:0] v8_r;
  face_t             face8_r;

  // ---------------------------------------------------------------------------
  // Configuration
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lut_size_r    <= 9'd129;
      warp_beta_r   <= 24'd65536;
      warp_gain_r   <= 24'd27146;
      warp_offset_r <= 24'd158217;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        CFG_LUT_SIZE:    lut_size_r    <= cfg_data[SIZE_W-1:0];
        CFG_WARP_BETA:   warp_beta_r   <= cfg_data[WARP_W-1:0];
        CFG_WARP_GAIN:   warp_gain_r   <= cfg_data[WARP_W-1:0];
        CFG_WARP_OFFSET: warp_offset_r <= cfg_data[WARP_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (lut_size_r < MIN_LUT_SIZE) begin
      size_nxt = MIN_LUT_SIZE;
    end else if (lut_size_r > MAX_LUT_SIZE) begin
      size_nxt = MAX_LUT_SIZE;
    end else begin
      size_nxt = lut_size_r;
    end
    size_m1_full = size_nxt - 9'd1;
  end

  // The grid values are only used from stage 5 on and are registered in the cycle after a write lands.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      size_r    <= 9'd129;
      size_m1_r <= 8'd128;
      half_r    <= 7'd64;
    end else begin
      size_r    <= size_nxt;
      size_m1_r <= size_m1_full[GRID_W-1:0];
      half_r    <= size_m1_full[GRID_W-1:1];
    end
  end

  assign lane_cfg = '{beta:    warp_beta_r,
                      gain:    warp_gain_r,
                      offset:  warp_offset_r,
                      size_m1: size_m1_r,
                      half:    half_r};

  // ---------------------------------------------------------------------------
  // Pipeline control: a stage loads when it is empty or its item moves on.
  // ---------------------------------------------------------------------------
  always_comb begin
    ld[NSTG] = !out_stall;
    for (int k = NSTG - 1; k >= 0; k--) begin
      ld[k] = !vld_r[k] || ld[k+1];
    end
  end

  assign in_stall = !ld[0];
  assign out_valid = vld_r[NSTG-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      if (ld[0]) begin
        vld_r[0] <= in_valid;
      end
      for (int k = 1; k < NSTG; k++) begin
        if (ld[k]) begin
          vld_r[k] <= vld_r[k-1];
        end
      end
    end
  end

  assign lane_ld = '{st1: ld[1], st2: ld[2], st3: ld[3],
                     st4: ld[4], st5: ld[5], st6: ld[6]};

  // ---------------------------------------------------------------------------
  // Stage 0 and face selection
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (ld[0]) begin
      x0_r <= in_dir_x;
      y0_r <= in_dir_y;
      z0_r <= in_dir_z;
    end
  end

  always_comb begin
    if (z0_r > FACE_LIMIT) begin
      face_sel = FACE_POS_Z;
      fu_sel   = x0_r;
      fv_sel   = y0_r;
    end else if (z0_r < NEG_FACE_LIMIT) begin
      face_sel = FACE_NEG_Z;
      fu_sel   = x0_r;
      fv_sel   = y0_r;
    end else if (x0_r > FACE_LIMIT) begin
      face_sel = FACE_POS_X;
      fu_sel   = z0_r;
      fv_sel   = y0_r;
    end else if (x0_r < NEG_FACE_LIMIT) begin
      face_sel = FACE_NEG_X;
      fu_sel   = z0_r;
      fv_sel   = y0_r;
    end else if (y0_r > 16'sd0) begin
      face_sel = FACE_POS_Y;
      fu_sel   = x0_r;
      fv_sel   = z0_r;
    end else begin
      face_sel = FACE_NEG_Y;
      fu_sel   = x0_r;
      fv_sel   = z0_r;
    end
  end

  always_ff @(posedge clk) begin
    if (ld[1]) begin
      face_r[1] <= face_sel;
    end
    for (int k = 2; k <= 7; k++) begin
      if (ld[k]) begin
        face_r[k] <= face_r[k-1];
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stages 1 to 6: one lane per in-face coordinate
  // ---------------------------------------------------------------------------
  cfla_grid_lane u_lane_u (
    .clk      (clk),
    .ld       (lane_ld),
    .cfg      (lane_cfg),
    .coord    (fu_sel),
    .grid_idx (u_idx)
  );

  cfla_grid_lane u_lane_v (
    .clk      (clk),
    .ld       (lane_ld),
    .cfg      (lane_cfg),
    .coord    (fv_sel),
    .grid_idx (v_idx)
  );

  // ---------------------------------------------------------------------------
  // Stages 7 and 8: table element offset 18*(u + v*size) + 3*face
  // ---------------------------------------------------------------------------
  assign m_nxt = 17'(v_idx) * 17'(size_r);

  always_ff @(posedge clk) begin
    if (ld[7]) begin
      u7_r <= u_idx;
      v7_r <= v_idx;
      m7_r <= m_nxt;
    end
  end

  always_comb begin
    cell_sum = {9'b0, u7_r} + m7_r;
    off_nxt  = {1'b0, cell_sum, 4'b0} + {4'b0, cell_sum, 1'b0}
             + {18'b0, face_r[7], 1'b0} + {19'b0, face_r[7]};
  end

  always_ff @(posedge clk) begin
    if (ld[8]) begin
      off8_r  <= off_nxt[OFFS_W-1:0];
      u8_r    <= u7_r;
      v8_r    <= v7_r;
      face8_r <= face_r[7];
    end
  end

  assign out_face       = face8_r;
  assign out_grid_u     = u8_r;
  assign out_grid_v     = v8_r;
  assign out_lut_offset = off8_r;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  `CFLA_ASSERT_IMP(a_grid_u_range, out_valid, out_grid_u <= size_m1_r,
                   "grid_u beyond the grid")
  `CFLA_ASSERT_IMP(a_grid_v_range, out_valid, out_grid_v <= size_m1_r,
                   "grid_v beyond the grid")
  `CFLA_ASSERT_IMP(a_stall_only_full, in_stall,
                   out_stall && ($countones(vld_r) == NSTG),
                   "input stalled while the pipeline has room")
  `CFLA_ASSERT_NXT(a_accept_enters, in_valid && !in_stall, vld_r[0],
                   "accepted item missing from the first stage")

endmodule

`default_nettype wire

FILE: rtl/cfla_grid_lane.sv
// One coordinate lane: warp, grid mapping and clamp over six register stages.
`default_nettype none

module cfla_grid_lane (
  input  logic                              clk,
  input  cfla_pkg::lane_load_t              ld,
  input  cfla_pkg::warp_cfg_t               cfg,
  input  logic signed [cfla_pkg::DIR_W-1:0] coord,
  output logic [cfla_pkg::GRID_W-1:0]       grid_idx
);
  import cfla_pkg::*;

  logic [DIR_W:0]    coord_ext;
  logic [DIR_W:0]    coord_neg;
  logic [DIR_W-1:0]  mag;
  logic [24:0]       a_nxt;
  logic              pos_nxt;

  logic [24:0]       a1_r;
  logic              pos1_r;

  logic [48:0]       prod;
  logic [32:0]       w2_r;
  logic              pos2_r;

  logic [23:0]       w_sat;
  logic [47:0]       sq_nxt;
  logic [47:0]       sq3_r;
  logic              pos3_r;

  logic [39:0]       bq;
  logic [49:0]       rp_nxt;
  logic [49:0]       rp4_r;

  logic signed [57:0] rp_ext;
  logic signed [57:0] half_ext;
  logic signed [57:0] t_prod;
  logic [57:0]       t_nxt;
  logic [57:0]       t5_r;

  logic [24:0]       idx_hi;
  logic [GRID_W-1:0] idx_nxt;
  logic [GRID_W-1:0] idx6_r;

  // Stage 1: magnitude scaled to Q.16 plus the warp offset.
  always_comb begin
    coord_ext = {coord[DIR_W-1], coord};
    coord_neg = -coord_ext;
    mag       = coord[DIR_W-1] ? coord_neg[DIR_W-1:0] : coord[DIR_W-1:0];
    a_nxt     = {7'b0, mag, 2'b00} + {1'b0, cfg.offset};
    // A zero coordinate counts as not positive.
    pos_nxt   = !coord[DIR_W-1] && (coord != '0);
  end

  always_ff @(posedge clk) begin
    if (ld.st1) begin
      a1_r   <= a_nxt;
      pos1_r <= pos_nxt;
    end
  end

  // Stage 2: gain product, kept in Q.16.
  assign prod = 49'(a1_r) * 49'(cfg.gain);

  always_ff @(posedge clk) begin
    if (ld.st2) begin
      w2_r   <= prod[48:16];
      pos2_r <= pos1_r;
    end
  end

  // Stage 3: saturate and square into Q.32.
  always_comb begin
    w_sat  = (|w2_r[32:24]) ? '1 : w2_r[23:0];
    sq_nxt = 48'(w_sat) * 48'(w_sat);
  end

  always_ff @(posedge clk) begin
    if (ld.st3) begin
      sq3_r  <= sq_nxt;
      pos3_r <= pos2_r;
    end
  end

  // Stage 4: signed warp result shifted up by one (r + 1 in Q.32).
  always_comb begin
    bq = {cfg.beta, 16'b0};
    if (pos3_r) begin
      rp_nxt = {2'b0, sq3_r} - {10'b0, bq} + Q32_ONE;
    end else begin
      rp_nxt = {10'b0, bq} - {2'b0, sq3_r} + Q32_ONE;
    end
  end

  always_ff @(posedge clk) begin
    if (ld.st4) begin
      rp4_r <= rp_nxt;
    end
  end

  // Stage 5: scale by half and take off one half grid step.
  always_comb begin
    rp_ext   = {{8{rp4_r[49]}}, rp4_r};
    half_ext = {51'b0, cfg.half};
    t_prod   = rp_ext * half_ext;
    t_nxt    = t_prod - Q31_HALF;
  end

  always_ff @(posedge clk) begin
    if (ld.st5) begin
      t5_r <= t_nxt;
    end
  end

  // Stage 6: truncate toward zero and clamp to the grid.
  always_comb begin
    idx_hi = t5_r[56:32];
    if (t5_r[57]) begin
      idx_nxt = '0;
    end else if ((|idx_hi[24:8]) || (idx_hi[7:0] > cfg.size_m1)) begin
      idx_nxt = cfg.size_m1;
    end else begin
      idx_nxt = idx_hi[7:0];
    end
  end

  always_ff @(posedge clk) begin
    if (ld.st6) begin
      idx6_r <= idx_nxt;
    end
  end

  assign grid_idx = idx6_r;

endmodule

`default_nettype wire
